// ===== rtl/bsp_pkg.sv =====
package bsp_pkg;

    // Fixed geometry of the configuration registers.
    localparam int NUM_CHARS = 16;
    localparam int LEN_W     = 5;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_BASE_LENGTH     = 2'd0;
    localparam logic [1:0] REG_BASE_CHARS_LOW  = 2'd1;
    localparam logic [1:0] REG_BASE_CHARS_HIGH = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef logic [NUM_CHARS-1:0][7:0] chars_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_start;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               base_valid;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0] base_length;
        chars_t           chars;
        logic             base_valid;
    } cfg_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ===== rtl/bsp_cfg.sv =====
module bsp_cfg
    import bsp_pkg::*;
#(
    parameter int MAX_BASE_CHARS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LEN_W-1:0] base_length_reg;
    logic [63:0]      chars_low_reg;
    logic [63:0]      chars_high_reg;
    logic             base_valid;
    logic             wr_en;
    chars_t           chars;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign chars  = {chars_high_reg, chars_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= '0;
            chars_low_reg   <= '0;
            chars_high_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (paddr[4:3])
                    REG_BASE_LENGTH:     base_length_reg <= pwdata[LEN_W-1:0];
                    REG_BASE_CHARS_LOW:  chars_low_reg   <= pwdata;
                    REG_BASE_CHARS_HIGH: chars_high_reg  <= pwdata;
                    default:             ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_BASE_LENGTH:     prdata = {{(APB_DW-LEN_W){1'b0}}, base_length_reg};
            REG_BASE_CHARS_LOW:  prdata = chars_low_reg;
            REG_BASE_CHARS_HIGH: prdata = chars_high_reg;
            default:             prdata = '0;
        endcase
    end

    // All pairwise compares run in parallel, so the verdict always matches the
    // registers as they stand.
    always_comb
    begin
        base_valid = (base_length_reg >= LEN_W'(2)) &&
                     (base_length_reg <= LEN_W'(MAX_BASE_CHARS));
        for (int i = 0; i < MAX_BASE_CHARS; i++)
        begin
            if (LEN_W'(i) < base_length_reg)
            begin
                if ((chars[i] == CH_NUL) || (chars[i] == CH_PLUS) ||
                    (chars[i] == CH_MINUS) || is_space(chars[i]))
                    base_valid = 1'b0;
                for (int j = i + 1; j < MAX_BASE_CHARS; j++)
                begin
                    if ((LEN_W'(j) < base_length_reg) && (chars[j] == chars[i]))
                        base_valid = 1'b0;
                end
            end
        end
    end

    assign cfg.base_length = base_length_reg;
    assign cfg.chars       = chars;
    assign cfg.base_valid  = base_valid;

endmodule

// ===== rtl/bsp_core.sv =====
module bsp_core
    import bsp_pkg::*;
#(
    parameter int MAX_BASE_CHARS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic        s1_valid_reg;
    item_t       s1_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        minus_reg;
    logic        minus_next;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;
    logic        emit;
    logic        out_free;
    logic        s1_fire;
    logic        item_accept;
    logic [1:0]  ph_eff;
    logic [31:0] acc_eff;
    logic        minus_eff;
    logic        digit_hit;
    logic [3:0]  digit;
    logic [7:0]  c;

    assign out_free    = !out_valid_reg || !result_stall;
    assign s1_fire     = s1_valid_reg && out_free;
    assign item_stall  = s1_valid_reg && !out_free;
    assign item_accept = item_valid && !item_stall;
    assign c           = s1_reg.char_in;

    // A string start clears the parse state before its first byte is seen.
    assign ph_eff    = s1_reg.string_start ? PH_SPACE : phase_reg;
    assign acc_eff   = s1_reg.string_start ? 32'd0 : acc_reg;
    assign minus_eff = s1_reg.string_start ? 1'b0 : minus_reg;

    // Lowest matching position wins.
    always_comb
    begin
        digit_hit = 1'b0;
        digit     = '0;
        for (int i = MAX_BASE_CHARS - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < cfg.base_length) && (cfg.chars[i] == c))
            begin
                digit_hit = 1'b1;
                digit     = 4'(i);
            end
        end
    end

    always_comb
    begin
        phase_next = ph_eff;
        acc_next   = acc_eff;
        minus_next = minus_eff;
        emit       = 1'b0;
        out_next   = '0;
        if (ph_eff == PH_DONE)
        begin
            emit = 1'b0;
        end
        else if (!cfg.base_valid)
        begin
            phase_next = PH_DONE;
            emit       = 1'b1;
        end
        else if ((ph_eff == PH_SPACE) && is_space(c))
        begin
            emit = 1'b0;
        end
        else if (((ph_eff == PH_SPACE) || (ph_eff == PH_SIGN)) &&
                 ((c == CH_PLUS) || (c == CH_MINUS)))
        begin
            phase_next = PH_SIGN;
            minus_next = minus_eff ^ (c == CH_MINUS);
        end
        else if (digit_hit)
        begin
            phase_next = PH_DIGIT;
            acc_next   = 32'(acc_eff * {{(32-LEN_W){1'b0}}, cfg.base_length}) +
                         {28'd0, digit};
        end
        else
        begin
            phase_next          = PH_DONE;
            emit                = 1'b1;
            out_next.value      = minus_eff ? (32'd0 - acc_eff) : acc_eff;
            out_next.base_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                minus_reg     <= minus_next;
                out_valid_reg <= emit;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
            s1_reg <= item;
        if (s1_fire && emit)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled while the holding stage could move");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("pending result lost or changed");

    a_invalid_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.base_valid) |-> (result.value == 32'd0))
        else $error("invalid base produced a nonzero value");

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> (phase_reg == PH_DONE))
        else $error("parser not done after emitting a result");

endmodule

// ===== rtl/base_string_to_int_parser.sv =====
// A character transfer is registered in the input register on acceptance and is
// parsed from there into the output register once that register is free.
// One character per cycle while no result is stalled, set by the digit compare
// and 32x5 multiply-add feeding the accumulator register.
// Reset (rst_n, asynchronous, active low) clears the configuration registers,
// parse state and stage valid flags; afterwards the base is invalid until written.
module base_string_to_int_parser
    import bsp_pkg::*;
#(
    parameter int MAX_BASE_CHARS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Character channel: one transfer per text byte.
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    // Result channel: one transfer per parsed string.
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    // The configuration block holds the digit characters and length, and it
    // derives the base validity verdict from them with parallel compares.
    cfg_t cfg;

    bsp_cfg #(
        .MAX_BASE_CHARS (MAX_BASE_CHARS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The core holds an input register, the parse state (phase, accumulator,
    // minus parity) and an output register. The input register is refilled
    // while a finished result waits on the output side, so a stalled result
    // transfer backs up into the character channel only when both are full.
    bsp_core #(
        .MAX_BASE_CHARS (MAX_BASE_CHARS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    import bsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of digit characters that the block supports; the DUT keeps its default.
    localparam int MAX_DIGITS = NUM_CHARS;

    // Parse phases of the predictor, in the order a well-formed string walks them.
    typedef enum logic [1:0] {
        SKIP_BLANKS,
        READ_SIGNS,
        READ_DIGITS,
        FINISHED
    } parse_phase_e;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;

    // Predictor's copy of the configuration registers.
    logic [LEN_W-1:0]  cfg_len;
    chars_t            cfg_chars;

    // Predictor's copy of the parse state.
    parse_phase_e      parse_phase;
    logic [31:0]       digit_acc;
    logic              minus_odd;

    // Parsed values that the block still owes, oldest first.
    result_t           pending_results[$];

    int                mismatches;
    int                chars_sent;     // character transfers so far
    int                send_gap_pct;
    int                stall_pct;

    base_string_to_int_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, even with every stall.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    // The base is usable only with 2 to 16 distinct characters, none of them a
    // sign, a blank or the zero byte.
    function automatic logic base_ok();
        if (cfg_len < 2 || cfg_len > MAX_DIGITS)
            return 1'b0;
        for (int i = 0; i < cfg_len; i++)
        begin
            if (cfg_chars[i] == CH_NUL || cfg_chars[i] == CH_PLUS ||
                cfg_chars[i] == CH_MINUS || is_blank(cfg_chars[i]))
                return 1'b0;
            for (int j = i + 1; j < cfg_len; j++)
                if (cfg_chars[j] == cfg_chars[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Digit value of c, or -1 when c is not one of the base characters.
    function automatic int digit_pos(input logic [7:0] c);
        for (int i = 0; i < cfg_len && i < MAX_DIGITS; i++)
            if (cfg_chars[i] == c)
                return i;
        return -1;
    endfunction

    // Advances the parse state by one accepted character and queues the value
    // that it completes, if any. Returns 0 when the character is ignored because
    // the string is already finished.
    function automatic logic parse_char(input logic [7:0] c, input logic s);
        int      d;
        result_t r;
        if (s)
        begin
            parse_phase = SKIP_BLANKS;
            digit_acc   = '0;
            minus_odd   = 1'b0;
        end
        if (parse_phase == FINISHED)
            return 1'b0;
        if (!base_ok())
        begin
            parse_phase  = FINISHED;
            r.value      = '0;
            r.base_valid = 1'b0;
            pending_results.push_back(r);
            return 1'b1;
        end
        if (parse_phase == SKIP_BLANKS && is_blank(c))
            return 1'b1;
        if ((parse_phase == SKIP_BLANKS || parse_phase == READ_SIGNS) &&
            (c == CH_PLUS || c == CH_MINUS))
        begin
            parse_phase = READ_SIGNS;
            if (c == CH_MINUS)
                minus_odd = ~minus_odd;
            return 1'b1;
        end
        d = digit_pos(c);
        if (d >= 0)
        begin
            parse_phase = READ_DIGITS;
            digit_acc   = digit_acc * 32'(cfg_len) + 32'(d);
            return 1'b1;
        end
        // Any other byte, the zero terminator included, closes the number.
        parse_phase  = FINISHED;
        r.value      = minus_odd ? 32'd0 - digit_acc : digit_acc;
        r.base_valid = 1'b1;
        pending_results.push_back(r);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall and the scoreboard check
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Every result transfer is compared with the oldest value still owed.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, value %0d base_valid %0b",
                         $time, result.value, result.base_valid);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.value !== want.value)
                begin
                    mismatches++;
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want.value, result.value);
                end
                if (result.base_valid !== want.base_valid)
                begin
                    mismatches++;
                    $display("%0t: base_valid mismatch, expected %0b, actual %0b",
                             $time, want.base_valid, result.base_valid);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one character transfer. Inputs change at the falling edge; a random
    // gap may come first, and the payload is held until the block takes it.
    task automatic send_char(input logic [7:0] c, input logic s);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{char_in: c, string_start: s};
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        void'(parse_char(c, s));
        chars_sent++;
    endtask

    // Stops sending, waits until every owed value has come back, then lets the
    // pipeline settle since a character that yields nothing may still be in it.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write: a setup phase, then an access phase that completes on pready.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_BASE_LENGTH:     cfg_len = data[LEN_W-1:0];
            REG_BASE_CHARS_LOW:  cfg_chars[7:0] = data;
            REG_BASE_CHARS_HIGH: cfg_chars[15:8] = data;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Loads a whole base. The length word carries random upper bits, which the
    // register must drop.
    task automatic write_base(input logic [LEN_W-1:0] len, input chars_t chars);
        logic [63:0] len_word;
        len_word = {$urandom(), $urandom()};
        len_word[LEN_W-1:0] = len;
        write_reg(REG_BASE_LENGTH, len_word);
        write_reg(REG_BASE_CHARS_LOW, chars[7:0]);
        write_reg(REG_BASE_CHARS_HIGH, chars[15:8]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // A byte that may legally serve as a digit character.
    function automatic logic [7:0] legal_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_PLUS || c == CH_MINUS || is_blank(c));
        return c;
    endfunction

    // A valid base of the given length; slots past the length hold junk.
    task automatic load_random_base(input int len);
        chars_t chars;
        logic   dup;
        for (int k = 0; k < MAX_DIGITS; k++)
            chars[k] = 8'($urandom());
        for (int k = 0; k < len; k++)
        begin
            do
            begin
                chars[k] = legal_char();
                dup = 1'b0;
                for (int j = 0; j < k; j++)
                    if (chars[j] == chars[k])
                        dup = 1'b1;
            end
            while (dup);
        end
        write_base(LEN_W'(len), chars);
    endtask

    function automatic logic [7:0] pick_digit();
        int n;
        n = (cfg_len >= 1 && cfg_len <= MAX_DIGITS) ? int'(cfg_len) : MAX_DIGITS;
        return cfg_chars[$urandom_range(n - 1)];
    endfunction

    // A well-formed number with random content: blanks, signs, digits, a
    // terminator of some kind, and a little trailing junk. Now and then the
    // start flag is left off, so the string runs on from the previous one.
    task automatic send_number();
        int          n_blank;
        int          n_sign;
        int          n_digit;
        int          n_tail;
        logic        first;
        logic [7:0]  term;
        first   = ($urandom_range(7) != 0);
        n_blank = $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0;
        n_sign  = $urandom_range(2) == 0 ? 0 : $urandom_range(1, 3);
        n_digit = $urandom_range(9) == 0 ? $urandom_range(11, 40) : $urandom_range(0, 10);
        n_tail  = $urandom_range(2);
        for (int k = 0; k < n_blank; k++)
        begin
            send_char(blank_char(), first);
            first = 1'b0;
        end
        for (int k = 0; k < n_sign; k++)
        begin
            send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, first);
            first = 1'b0;
        end
        for (int k = 0; k < n_digit; k++)
        begin
            send_char(pick_digit(), first);
            first = 1'b0;
        end
        case ($urandom_range(3))
            0:       term = CH_NUL;
            1:       term = blank_char();
            2:       term = $urandom_range(1) ? CH_PLUS : CH_MINUS;
            default: term = 8'($urandom());
        endcase
        send_char(term, first);
        for (int k = 0; k < n_tail; k++)
            send_char(8'($urandom()), 1'b0);
    endtask

    // Raw bytes with occasional start flags in the middle.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            send_char(8'($urandom()), k == 0 || $urandom_range(9) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset the base is empty and so invalid. The very first byte has no
    // start flag and must still be parsed as a new string; the byte after it is
    // ignored, and a start flag with the top byte value opens a fresh string.
    task automatic test_reset_state();
        send_char("7", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // Decimal base: every blank kind is skipped, a mixed sign run with three
    // minus signs negates, and a blank after digits ends the number. A blank
    // right after a sign ends the number too, and an empty string yields zero.
    task automatic test_sign_and_blank_handling();
        drain_results();
        write_base(LEN_W'(10), "9876543210");
        send_char(CH_SPACE, 1'b1);
        send_char(CH_TAB, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_VT, 1'b0);
        send_char(CH_FF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char("7", 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_MINUS, 1'b1);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_NUL, 1'b1);
        send_char("5", 1'b0);
    endtask

    // Hex base at full length: negating the most negative value gives itself.
    task automatic test_most_negative();
        string digits;
        digits = "-80000000";
        drain_results();
        write_base(LEN_W'(16), "FEDCBA9876543210");
        for (int k = 0; k < digits.len(); k++)
            send_char(digits[k], k == 0);
        send_char(CH_NUL, 1'b0);
    endtask

    // Each way a base can be rejected: too short, too long, a repeated
    // character, a sign, a blank and a zero byte among the used characters.
    task automatic test_invalid_bases();
        chars_t chars;
        drain_results();
        write_base(LEN_W'(1), "9876543210");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        write_base(LEN_W'(17), "FEDCBA9876543210");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        write_base(LEN_W'(31), "FEDCBA9876543210");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        write_base(LEN_W'(3), "aba");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        write_base(LEN_W'(3), "1+0");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        write_base(LEN_W'(3), "1-0");
        send_char(8'($urandom()), 1'b1);
        drain_results();
        chars    = "10";
        chars[2] = blank_char();
        write_base(LEN_W'(3), chars);
        send_char(8'($urandom()), 1'b1);
        drain_results();
        // Byte 2 of the base stays zero here.
        write_base(LEN_W'(3), "12");
        send_char(8'($urandom()), 1'b1);
    endtask

    // Random strings over several bases: the two length extremes, one phase
    // with an arbitrary (mostly invalid) base, one phase with no idling on
    // either side, and one phase where the sender waits for the results.
    task automatic test_random_strings();
        chars_t chars;
        int     mark;
        logic   paused;
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            send_gap_pct = (p == 3) ? 0 : 10;
            stall_pct    = (p == 3) ? 0 : 10;
            case (p)
                0: load_random_base(2);
                1: load_random_base(MAX_DIGITS);
                2:
                begin
                    for (int k = 0; k < MAX_DIGITS; k++)
                        chars[k] = 8'($urandom());
                    write_base(LEN_W'($urandom_range(0, 31)), chars);
                end
                default: load_random_base($urandom_range(2, MAX_DIGITS));
            endcase
            mark   = chars_sent;
            paused = 1'b0;
            while (chars_sent - mark < 125)
            begin
                if (p == 5 && !paused && chars_sent - mark > 60)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85)
                    send_number();
                else
                    send_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_len      = '0;
        cfg_chars    = '0;
        parse_phase  = SKIP_BLANKS;
        digit_acc    = '0;
        minus_odd    = 1'b0;
        mismatches   = 0;
        chars_sent   = 0;
        send_gap_pct = 10;
        stall_pct    = 10;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_sign_and_blank_handling();
        test_most_negative();
        test_invalid_bases();
        test_random_strings();

        // Let the last values come back, with a bound, then keep the clock running idle
        // so that any stray result transfer is still caught.
        @(negedge clk);
        item_valid <= 1'b0;
        for (int n = 0; n < 2000 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived, oldest value %0d",
                     $time, pending_results.size(), pending_results[0].value);
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== base_string_to_int_parser.f =====
rtl/bsp_pkg.sv
rtl/bsp_cfg.sv
rtl/bsp_core.sv
rtl/base_string_to_int_parser.sv
sim/tb.sv
